// ===== rtl/lrcs_pkg.sv =====
// Shared types and constants for the largest row or column sum block.
// Used by every module of the block but lrcs_ram; depends on nothing.
`default_nettype none

package lrcs_pkg;

    // Fixed field widths.
    localparam int ELEM_W = 32;
    localparam int SUM_W  = 38;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;

    // Default matrix limits.
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Result queue depth and the width of its fill level.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [0:0] REG_NUM_ROWS = 1'b0;
    localparam logic [0:0] REG_NUM_COLS = 1'b1;

    // One result item.
    typedef struct packed {
        logic signed [SUM_W-1:0] winner_sum;
        logic [IDX_W-1:0]        winner_index;
        logic                    winner_is_column;
    } result_t;

    // A result request from the core into the result queue.
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_push_t;

endpackage

`default_nettype wire

// ===== rtl/lrcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the per-column running sums in this block.
`default_nettype none

module lrcs_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; returns the old contents on a same-address write.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrcs_outq.sv =====
// Small result queue that decouples the core from the result channel.
// Depends on lrcs_pkg for the result types and queue depth.
`default_nettype none

module lrcs_outq
    import lrcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire result_push_t          push,
    output logic [OUTQ_LVL_W-1:0]      level,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output result_t                    head
);

    localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;

    result_t                 slots [OUTQ_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_next;
    logic [OUTQ_LVL_W-1:0]   level_reg;
    logic [OUTQ_LVL_W-1:0]   level_next;
    logic                    pop;

    assign m_valid = (level_reg != '0);
    assign head    = slots[rd_ptr_reg];
    assign level   = level_reg;
    assign pop     = m_valid && m_ready;

    // Pointer and fill level update with wraparound at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push.valid && pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Result storage.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slots[wr_ptr_reg] <= push.data;
        end
    end

    // The core only pushes when a slot is guaranteed free.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (level_reg != OUTQ_LVL_W'(OUTQ_DEPTH)) || pop)
        else $error("result queue overflow");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= OUTQ_LVL_W'(OUTQ_DEPTH))
        else $error("result queue level out of range");

    a_level_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && !pop) |=> (level_reg == $past(level_reg) + 1'b1))
        else $error("result queue level did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/lrcs_core.sv =====
// Accumulation pipeline: column sums in RAM with read-modify-write and forwarding,
// running row sum, best row and column tracking. Depends on lrcs_pkg and lrcs_ram.
`default_nettype none

module lrcs_core
    import lrcs_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [0:0]              cfg_addr,
    input  wire logic [CFG_W-1:0]        cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [ELEM_W-1:0] s_value,
    input  wire logic [OUTQ_LVL_W-1:0]   outq_level,
    output result_push_t                 push
);

    // Position widths and count widths follow from the limits.
    localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CPW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;

    // Stage 0 position counters.
    logic [RPW-1:0] row_pos_reg;
    logic [RPW-1:0] row_pos_next;
    logic [CPW-1:0] col_pos_reg;
    logic [CPW-1:0] col_pos_next;
    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;
    logic [RCW-1:0] rows_cfg;
    logic [CCW-1:0] cols_cfg;
    logic           last_col;
    logic           last_row;
    logic           accept;

    // Stage 1 request registers.
    logic                     s1_valid_reg;
    logic signed [ELEM_W-1:0] s1_value_reg;
    logic [CPW-1:0]           s1_addr_reg;
    logic [RPW-1:0]           s1_row_reg;
    logic                     s1_row0_reg;
    logic                     s1_col0_reg;
    logic                     s1_last_col_reg;
    logic                     s1_last_row_reg;
    logic                     s1_fwd_reg;
    logic signed [SUM_W-1:0]  s1_fwd_data_reg;
    logic                     s1_emit;

    // Stage 1 arithmetic.
    logic signed [SUM_W-1:0]  ram_rdata;
    logic signed [SUM_W-1:0]  operand;
    logic signed [SUM_W-1:0]  value_ext;
    logic signed [SUM_W-1:0]  csum;
    logic signed [SUM_W-1:0]  row_sum_new;

    // Tracked sums and indexes.
    logic signed [SUM_W-1:0]  row_sum_reg;
    logic signed [SUM_W-1:0]  best_row_sum_reg;
    logic [RPW-1:0]           best_row_idx_reg;
    logic signed [SUM_W-1:0]  best_col_sum_reg;
    logic [CPW-1:0]           best_col_idx_reg;

    // Stage 2 result request.
    logic                     s2_emit_reg;
    logic                     col_wins;
    logic [OUTQ_LVL_W-1:0]    inflight;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= CFG_W'(1);
            num_cols_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                REG_NUM_COLS: num_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective counts: zero acts as one, anything above the limit as the limit.
    always_comb begin
        rows_cfg = RCW'(num_rows_reg);
        cols_cfg = CCW'(num_cols_reg);
        if (rows_cfg == '0) begin
            rows_eff = RCW'(1);
        end else if (rows_cfg > RCW'(MAX_ROWS)) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = rows_cfg;
        end
        if (cols_cfg == '0) begin
            cols_eff = CCW'(1);
        end else if (cols_cfg > CCW'(MAX_COLS)) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = cols_cfg;
        end
    end

    // Accept while every result that may still appear has a queue slot.
    assign s1_emit  = s1_valid_reg && s1_last_col_reg && s1_last_row_reg;
    assign inflight = outq_level + OUTQ_LVL_W'(s1_emit) + OUTQ_LVL_W'(s2_emit_reg);
    assign s_ready  = (inflight < OUTQ_LVL_W'(OUTQ_DEPTH));
    assign accept   = s_valid && s_ready;

    // Row-major position stepping.
    assign last_col = (CCW'(col_pos_reg) + CCW'(1)) >= cols_eff;
    assign last_row = (RCW'(row_pos_reg) + RCW'(1)) >= rows_eff;

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (last_col) begin
            col_pos_next = '0;
            row_pos_next = last_row ? '0 : row_pos_reg + 1'b1;
        end else begin
            col_pos_next = col_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
        end
    end

    // Stage 1 payload; forward the sum being written when the same column is read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg    <= s_value;
            s1_addr_reg     <= col_pos_reg;
            s1_row_reg      <= row_pos_reg;
            s1_row0_reg     <= (row_pos_reg == '0);
            s1_col0_reg     <= (col_pos_reg == '0);
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            s1_fwd_reg      <= s1_valid_reg && (s1_addr_reg == col_pos_reg);
            s1_fwd_data_reg <= csum;
        end
    end

    // Column sum storage.
    lrcs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (csum),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rdata)
    );

    // Column and row sum update; the first row overwrites the column entry.
    assign value_ext   = {{(SUM_W - ELEM_W){s1_value_reg[ELEM_W-1]}}, s1_value_reg};
    assign operand     = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign csum        = s1_row0_reg ? value_ext : operand + value_ext;
    assign row_sum_new = s1_col0_reg ? value_ext : row_sum_reg + value_ext;

    // Best row and best column tracking; the first candidate always wins.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg      <= '0;
            best_row_sum_reg <= '0;
            best_row_idx_reg <= '0;
            best_col_sum_reg <= '0;
            best_col_idx_reg <= '0;
            s2_emit_reg      <= 1'b0;
        end else begin
            s2_emit_reg <= s1_emit;
            if (s1_valid_reg) begin
                row_sum_reg <= row_sum_new;
                if (s1_last_row_reg && (s1_col0_reg || (csum > best_col_sum_reg))) begin
                    best_col_sum_reg <= csum;
                    best_col_idx_reg <= s1_addr_reg;
                end
                if (s1_last_col_reg && (s1_row0_reg || (row_sum_new > best_row_sum_reg))) begin
                    best_row_sum_reg <= row_sum_new;
                    best_row_idx_reg <= s1_row_reg;
                end
            end
        end
    end

    // Stage 2: a column wins only when strictly greater than the best row.
    assign col_wins = best_col_sum_reg > best_row_sum_reg;

    always_comb begin
        push.valid                 = s2_emit_reg;
        push.data.winner_is_column = col_wins;
        push.data.winner_index     = col_wins ? IDX_W'(best_col_idx_reg)
                                              : IDX_W'(best_row_idx_reg);
        push.data.winner_sum       = col_wins ? best_col_sum_reg : best_row_sum_reg;
    end

    // Back-to-back requests to one column must take the forwarded sum.
    a_fwd_same_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && $past(s1_valid_reg) && (s1_addr_reg == $past(s1_addr_reg)))
        |-> s1_fwd_reg)
        else $error("column sum forwarding missed");

    a_emit_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_emit_reg |-> $past(s1_valid_reg && s1_last_col_reg && s1_last_row_reg))
        else $error("result emitted without a closing element");

    a_stage1_source: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $past(s_valid && s_ready))
        else $error("stage 1 holds an element that was never accepted");

endmodule

`default_nettype wire

// ===== rtl/largest_row_or_column_sum_top.sv =====
// Largest row or column sum: streams a matrix in and reports the winning line.
// Usage notes follow. Depends on lrcs_pkg, lrcs_core, lrcs_ram and lrcs_outq.
//
// Elements enter on the s_ channel, one request per element, in row-major order.
// Write num_rows (index 0) and num_cols (index 1) on the cfg port while idle;
// both reset to 1. After the last element of a matrix one result leaves on the
// m_ channel: the row or column flag on m_tuser, and the index and the 38-bit
// signed sum on m_tdata. The first row with the greatest sum wins unless the
// first column with the greatest sum is strictly greater.
// Throughput is one element per cycle while s_tready is high: each element does
// one read-modify-write of its column sum in a RAM with a registered read, and
// the sum just written is forwarded when the next element hits the same column.
// A finished result is registered in stage 2 and then in the queue before m_tvalid.
// A four-entry result queue holds finished results while the receiver stalls;
// s_tready drops only when that queue could otherwise overflow.
// Reset clears the counters, sums and the queue. The column RAM is not cleared:
// the first row of each matrix overwrites its entries.
`default_nettype none

module largest_row_or_column_sum_top
    import lrcs_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration write port.
    input  wire logic               cfg_wr_en,
    input  wire logic [0:0]         cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    // Element channel.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // [31:0] element_value
    // Result channel.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [47:0]             m_tdata,   // [5:0] winner_index, [43:6] winner_sum,
                                               // [47:44] zero
    output logic                    m_tuser    // [0] winner_is_column
);

    result_push_t             push;
    result_t                  head;
    logic [OUTQ_LVL_W-1:0]    outq_level;

    // Accumulation pipeline.
    lrcs_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_value    (s_tdata[ELEM_W-1:0]),
        .outq_level (outq_level),
        .push       (push)
    );

    // Result queue in front of the output channel.
    lrcs_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .level   (outq_level),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .head    (head)
    );

    // Pack the result fields, lowest field first; the row or column flag rides on tuser.
    assign m_tdata = {4'b0000, head.winner_sum, head.winner_index};
    assign m_tuser = head.winner_is_column;

endmodule

`default_nettype wire

// ===== test/lrcs_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the largest row or column sum block. It follows the
// configuration, element and result ports, predicts every winner and compares.
// Depends on lrcs_pkg for the result layout, the widths and the register indexes.
module lrcs_checker
    import lrcs_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [31:0]      s_tdata,    // [31:0] element_value
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [47:0]      m_tdata,    // [5:0] winner_index, [43:6] winner_sum,
                                         // [47:44] zero
    input  logic             m_tuser,    // [0] winner_is_column
    output int               failures,
    output int               outstanding
);

    localparam int DATA_W = IDX_W + SUM_W;

    // Own copy of the counts and of the running sums.
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    longint           col_sums [MAX_COLS];
    longint           row_sum;
    longint           best_row_sum;
    longint           best_col_sum;
    int unsigned      best_row_at;
    int unsigned      best_col_at;
    int unsigned      row_at;
    int unsigned      col_at;
    int               fail_count;
    result_t          winner_q [$];

    // A count of zero acts as one and a count above the limit acts as the limit.
    function automatic int unsigned line_count(input logic [CFG_W-1:0] value,
                                               input int unsigned limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    always @(posedge aclk) begin : follow
        result_t     got;
        result_t     want;
        int unsigned rows;
        int unsigned cols;
        int unsigned slot;
        longint      elem;
        longint      csum;
        bit          col_wins;
        if (!aresetn) begin
            rows_reg = 1;
            cols_reg = 1;
            foreach (col_sums[i])
                col_sums[i] = 0;
            row_sum      = 0;
            best_row_sum = 0;
            best_col_sum = 0;
            best_row_at  = 0;
            best_col_at  = 0;
            row_at       = 0;
            col_at       = 0;
            winner_q.delete();
        end else begin
            // Compare each result request with the oldest predicted winner.
            if (m_tvalid && m_tready) begin
                got.winner_is_column = m_tuser;
                got.winner_index     = m_tdata[IDX_W-1:0];
                got.winner_sum       = m_tdata[DATA_W-1:IDX_W];
                if (winner_q.size() == 0) begin
                    $display("%0t: unexpected result: column %0b index %0d sum %0d",
                             $time, got.winner_is_column, got.winner_index,
                             got.winner_sum);
                    fail_count++;
                end else begin
                    want = winner_q.pop_front();
                    if (got.winner_is_column !== want.winner_is_column) begin
                        $display("%0t: winner_is_column expected %0b, got %0b",
                                 $time, want.winner_is_column, got.winner_is_column);
                        fail_count++;
                    end
                    if (got.winner_index !== want.winner_index) begin
                        $display("%0t: winner_index expected %0d, got %0d",
                                 $time, want.winner_index, got.winner_index);
                        fail_count++;
                    end
                    if (got.winner_sum !== want.winner_sum) begin
                        $display("%0t: winner_sum expected %0d, got %0d",
                                 $time, want.winner_sum, got.winner_sum);
                        fail_count++;
                    end
                    if (m_tdata[47:DATA_W] !== '0) begin
                        $display("%0t: result padding expected 0, got %0h",
                                 $time, m_tdata[47:DATA_W]);
                        fail_count++;
                    end
                end
            end

            // Fold each element request into the row and column sums.
            if (s_tvalid && s_tready) begin
                rows = line_count(rows_reg, MAX_ROWS);
                cols = line_count(cols_reg, MAX_COLS);
                elem = longint'(signed'(s_tdata));
                slot = (col_at >= MAX_COLS) ? MAX_COLS - 1 : col_at;

                // The first row overwrites the column entry instead of adding.
                csum = (row_at == 0) ? elem : col_sums[slot] + elem;
                col_sums[slot] = csum;
                row_sum = (col_at == 0) ? elem : row_sum + elem;

                // Columns compete only on the last row; column 0 always sets the best.
                if (row_at >= rows - 1 && (col_at == 0 || csum > best_col_sum)) begin
                    best_col_sum = csum;
                    best_col_at  = col_at;
                end

                if (col_at >= cols - 1) begin
                    if (row_at == 0 || row_sum > best_row_sum) begin
                        best_row_sum = row_sum;
                        best_row_at  = row_at;
                    end
                    col_at = 0;
                    if (row_at >= rows - 1) begin
                        // A column wins only when it is strictly greater.
                        col_wins              = best_col_sum > best_row_sum;
                        want.winner_is_column = col_wins;
                        want.winner_index     = col_wins ? IDX_W'(best_col_at)
                                                         : IDX_W'(best_row_at);
                        want.winner_sum       = col_wins ? SUM_W'(best_col_sum)
                                                         : SUM_W'(best_row_sum);
                        winner_q.push_back(want);
                        row_at = 0;
                    end else begin
                        row_at++;
                    end
                end else begin
                    col_at++;
                end
            end

            // Register writes take effect for the next element.
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_NUM_ROWS: rows_reg = cfg_wdata;
                    REG_NUM_COLS: cols_reg = cfg_wdata;
                    default: ;
                endcase
            end
        end
        failures    <= fail_count;
        outstanding <= winner_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the largest row or column sum testbench: clock, reset, stimulus, verdict.
// Depends on lrcs_pkg, largest_row_or_column_sum_top and lrcs_checker.
module testbench;
    import lrcs_pkg::*;

    localparam int RANDOM_ITEMS = 1100;

    typedef enum int {VAL_ANY, VAL_TIES, VAL_EDGES, VAL_BIG} value_mix_t;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [0:0]       cfg_addr  = REG_NUM_ROWS;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;
    logic             m_tuser;
    int               failures;
    int               outstanding;

    // Idle rates in percent for each side.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    // Matrix shape as the block sees it and where the next element lands.
    int unsigned shape_rows     = 1;
    int unsigned shape_cols     = 1;
    int unsigned next_row       = 0;
    int unsigned next_col       = 0;
    int          elements_sent  = 0;

    largest_row_or_column_sum_top dut (.*);

    lrcs_checker winner_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver stalls at random.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [31:0] pick_element(input value_mix_t mix);
        case (mix)
            VAL_TIES:  return 32'(int'($urandom_range(6)) - 3);
            VAL_EDGES: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
            VAL_BIG:   return {($urandom_range(1) != 0) ? 2'b01 : 2'b10, 30'($urandom)};
            default:   return $urandom;
        endcase
    endfunction

    // Writes one count register and tracks the count the block will use.
    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        int unsigned limit;
        limit = (idx == REG_NUM_ROWS) ? DEF_MAX_ROWS : DEF_MAX_COLS;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_NUM_ROWS)
            shape_rows = (value == 0) ? 1 : (value > limit) ? limit : value;
        else
            shape_cols = (value == 0) ? 1 : (value > limit) ? limit : value;
    endtask

    // Sends one element request after a random gap and follows the position.
    task automatic send_element(input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        elements_sent++;
        if (next_col >= shape_cols - 1) begin
            next_col = 0;
            next_row = (next_row >= shape_rows - 1) ? 0 : next_row + 1;
        end else begin
            next_col++;
        end
    endtask

    // Sends elements until the current matrix closes.
    task automatic send_matrix(input value_mix_t mix);
        do
            send_element(pick_element(mix));
        while (next_row != 0 || next_col != 0);
    endtask

    // Stops sending and waits until every predicted result has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        @(negedge aclk);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            IDLE_BOTH: begin send_idle_pct = 32; recv_stall_pct = 32; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int          matrices;
        int          start_count;
        int unsigned part;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-element matrices with the counts from reset, at the extremes.
        send_element(32'h8000_0000);
        send_element(32'h7FFF_FFFF);
        settle();

        // Counts of zero act as one.
        write_reg(REG_NUM_ROWS, 0);
        write_reg(REG_NUM_COLS, 0);
        send_element(32'h0000_0001);
        settle();

        // Two equal rows, and the middle column strictly greater.
        write_reg(REG_NUM_ROWS, 2);
        write_reg(REG_NUM_COLS, 3);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0004);
        send_element(32'hFFFF_FFFF);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0004);
        send_element(32'hFFFF_FFFF);
        settle();

        // The first row wins over weaker columns, then every line ties at the minimum.
        write_reg(REG_NUM_COLS, 2);
        send_element(32'h0000_0002);
        send_element(32'h0000_0002);
        send_element(32'hFFFF_FFFD);
        send_element(32'hFFFF_FFFD);
        repeat (4)
            send_element(32'h8000_0000);
        settle();

        // Shrinking the column count mid-matrix closes the row at once.
        write_reg(REG_NUM_ROWS, 3);
        write_reg(REG_NUM_COLS, 3);
        repeat (4)
            send_element(pick_element(VAL_ANY));
        settle();
        write_reg(REG_NUM_COLS, 1);
        send_matrix(VAL_EDGES);

        // Random matrices, mostly small, with the idle mode rotating.
        matrices    = 0;
        start_count = elements_sent;
        while (elements_sent - start_count < RANDOM_ITEMS) begin
            if (matrices % 6 == 0) begin
                settle();
                set_idling(idle_mode_t'((matrices / 6) % 4));
            end

            // New counts between matrices; a few runs use the largest sizes.
            if ($urandom_range(2) == 0) begin
                settle();
                case ($urandom_range(29))
                    0: begin
                        write_reg(REG_NUM_ROWS, 127);
                        write_reg(REG_NUM_COLS, CFG_W'($urandom_range(1)));
                    end
                    1: begin
                        write_reg(REG_NUM_ROWS, 0);
                        write_reg(REG_NUM_COLS, 127);
                    end
                    2: begin
                        write_reg(REG_NUM_ROWS, CFG_W'($urandom_range(1, 2)));
                        write_reg(REG_NUM_COLS, 64);
                    end
                    3: begin
                        write_reg(REG_NUM_ROWS, 64);
                        write_reg(REG_NUM_COLS, CFG_W'($urandom_range(1, 2)));
                    end
                    default: begin
                        write_reg(REG_NUM_ROWS, CFG_W'($urandom_range(1, 6)));
                        write_reg(REG_NUM_COLS, CFG_W'($urandom_range(1, 6)));
                    end
                endcase
            end

            // Now and then the counts change partway through a matrix. The column
            // count only shrinks there, so no unwritten column entry is ever read.
            if ($urandom_range(7) == 0 && shape_rows * shape_cols > 1) begin
                part = $urandom_range(1, shape_rows * shape_cols - 1);
                repeat (part)
                    send_element(pick_element(value_mix_t'($urandom_range(3))));
                settle();
                if ($urandom_range(1) == 0)
                    write_reg(REG_NUM_ROWS, CFG_W'($urandom_range(8)));
                else
                    write_reg(REG_NUM_COLS, CFG_W'($urandom_range(shape_cols)));
            end

            send_matrix(value_mix_t'($urandom_range(3)));
            matrices++;
        end

        settle();
        if (failures == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
